// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the conductance LIF neuron block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons starting in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/clif_pkg.sv -----
// Types and constants of the conductance LIF neuron update block.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none

package clif_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 8;
  localparam int CFG_IDX_W = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EXC_DECAY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INH_DECAY    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXC_REVERSAL = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INH_REVERSAL = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEVEL  = 4'd7;

  // Register reset values
  localparam logic [VAL_W-1:0] RST_EXC_DECAY    = 16'd655;
  localparam logic [VAL_W-1:0] RST_INH_DECAY    = 16'd655;
  localparam logic [VAL_W-1:0] RST_LEAK_RATE    = 16'd328;
  localparam logic [VAL_W-1:0] RST_EXC_REVERSAL = 16'h0000;
  localparam logic [VAL_W-1:0] RST_INH_REVERSAL = 16'hB000;
  localparam logic [VAL_W-1:0] RST_REST_LEVEL   = 16'hC400;
  localparam logic [VAL_W-1:0] RST_THRESHOLD    = 16'hCE00;
  localparam logic [VAL_W-1:0] RST_RESET_LEVEL  = 16'hC400;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [IDX_W-1:0] neuron_index;
    logic [VAL_W-1:0] exc_input;
    logic [VAL_W-1:0] inh_input;
  } clif_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic                    spiked;
    logic signed [VAL_W-1:0] membrane;
  } clif_out_t;

  typedef struct packed {
    logic [VAL_W-1:0]        exc_decay;
    logic [VAL_W-1:0]        inh_decay;
    logic [VAL_W-1:0]        leak_rate;
    logic signed [VAL_W-1:0] exc_reversal;
    logic signed [VAL_W-1:0] inh_reversal;
    logic signed [VAL_W-1:0] rest_level;
    logic signed [VAL_W-1:0] threshold;
    logic signed [VAL_W-1:0] reset_level;
  } clif_cfg_t;

  // One word of the per-neuron state memory
  typedef struct packed {
    logic signed [VAL_W-1:0] potential;
    logic [VAL_W-1:0]        g_exc;
    logic [VAL_W-1:0]        g_inh;
    logic [CNT_W-1:0]        since_spike;
  } clif_state_t;

  localparam clif_state_t STATE_RESET = '{
    potential:   RST_REST_LEVEL,
    g_exc:       '0,
    g_inh:       '0,
    since_spike: CNT_MAX
  };

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write the reset word at the clear address and advance
    logic load;    // capture the input word and read its state
    logic commit;  // write back the state and load the output register
  } clif_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } clif_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clif_ctrl.sv -----
// Sequencer of the conductance LIF neuron update: clear pass, item steps,
// input and output handshakes. Depends on clif_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module clif_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output clif_pkg::clif_cmd_t        cmd,
  input  wire clif_pkg::clif_status_t status
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CG    = 3'd2;
  localparam logic [2:0] S_CU    = 3'd3;
  localparam logic [2:0] S_MV    = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall   = (state != S_IDLE);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.commit = (state == S_WB) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_CG;
      S_CG:    state_next = S_CU;
      S_CU:    state_next = S_MV;
      S_MV:    state_next = S_SUM;
      S_SUM:   state_next = S_WB;
      S_WB:    if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NOW(a_no_overwrite, clk, rst, cmd.commit, !out_valid || !out_stall)
  `ASSERT_NEXT(a_load_to_wb, clk, rst, cmd.load, ##4 (state == S_WB))
  `ASSERT_NOW(a_clear_quiet, clk, rst, state == S_CLEAR, !out_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/clif_dp.sv -----
// Datapath of the conductance LIF neuron update: state memory, conductance
// decay, membrane step, spike test. Depends on clif_pkg.
`default_nettype none

module clif_dp #(
  parameter int NEURONS          = 1024,
  parameter int REFRACTORY_TICKS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire clif_pkg::clif_cmd_t  cmd,
  output clif_pkg::clif_status_t    status,
  input  wire clif_pkg::clif_cfg_t  cfg,
  input  wire clif_pkg::clif_in_t   in_data,
  output clif_pkg::clif_out_t       out_data
);

  localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int EXT_W  = 17;

  clif_pkg::clif_state_t mem [NEURONS];

  logic [ADDR_W-1:0] clr_addr;

  // Captured item
  logic [EXT_W-1:0]  idx_ext;
  logic              in_range_now;
  logic [ADDR_W-1:0] rd_addr;
  clif_pkg::clif_state_t cur;
  logic [clif_pkg::IDX_W-1:0] idx;
  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic [clif_pkg::VAL_W-1:0] exc_in;
  logic [clif_pkg::VAL_W-1:0] inh_in;

  // Step registers
  logic [31:0] prod_e;
  logic [31:0] prod_i;
  logic [clif_pkg::CNT_W-1:0] cnt_inc;
  logic        active;
  logic [clif_pkg::VAL_W-1:0] ge;
  logic [clif_pkg::VAL_W-1:0] gi;
  logic signed [16:0] de;
  logic signed [16:0] di;
  logic signed [16:0] dl;
  logic signed [33:0] pe;
  logic signed [33:0] pi;
  logic signed [33:0] pl;
  logic signed [19:0] dv;

  // Combinational values
  logic [clif_pkg::CNT_W-1:0] cnt_inc_next;
  logic [32:0] round_e;
  logic [32:0] round_i;
  logic [16:0] sum_e;
  logic [16:0] sum_i;
  logic signed [16:0] v_ext;
  logic signed [35:0] s_sum;
  logic signed [20:0] nv;
  logic signed [clif_pkg::VAL_W-1:0] v_sat;
  logic        spike;
  logic signed [clif_pkg::VAL_W-1:0] v_new;
  logic [clif_pkg::CNT_W-1:0] cnt_new;

  assign idx_ext      = EXT_W'(in_data.neuron_index);
  assign in_range_now = (idx_ext < EXT_W'(NEURONS));
  assign rd_addr      = in_range_now ? idx_ext[ADDR_W-1:0] : '0;

  assign status.clear_last = (clr_addr == ADDR_W'(NEURONS - 1));

  // Clear pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // State memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= clif_pkg::STATE_RESET;
    end else if (cmd.commit && in_range) begin
      mem[addr] <= '{potential: v_new, g_exc: ge, g_inh: gi, since_spike: cnt_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur      <= mem[rd_addr];
      idx      <= in_data.neuron_index;
      addr     <= rd_addr;
      in_range <= in_range_now;
      exc_in   <= in_data.exc_input;
      inh_in   <= in_data.inh_input;
    end
  end

  // Conductance decay products and refractory count
  assign cnt_inc_next = (cur.since_spike == clif_pkg::CNT_MAX) ? clif_pkg::CNT_MAX
                                                                : cur.since_spike + 1'b1;

  always_ff @(posedge clk) begin
    prod_e  <= 32'(cur.g_exc) * 32'(cfg.exc_decay);
    prod_i  <= 32'(cur.g_inh) * 32'(cfg.inh_decay);
    cnt_inc <= cnt_inc_next;
    active  <= (cnt_inc_next > clif_pkg::CNT_W'(REFRACTORY_TICKS));
  end

  // Rounded loss, add input, saturate; distances to the three levels
  assign round_e = 33'(prod_e) + 33'd32768;
  assign round_i = 33'(prod_i) + 33'd32768;
  assign sum_e   = 17'(cur.g_exc) - 17'(round_e[31:16]) + 17'(exc_in);
  assign sum_i   = 17'(cur.g_inh) - 17'(round_i[31:16]) + 17'(inh_in);
  assign v_ext   = 17'(cur.potential);

  always_ff @(posedge clk) begin
    ge <= sum_e[16] ? '1 : sum_e[15:0];
    gi <= sum_i[16] ? '1 : sum_i[15:0];
    de <= 17'(cfg.exc_reversal) - v_ext;
    di <= 17'(cfg.inh_reversal) - v_ext;
    dl <= 17'(cfg.rest_level) - v_ext;
  end

  // Three drive products
  always_ff @(posedge clk) begin
    pe <= $signed({1'b0, ge}) * de;
    pi <= $signed({1'b0, gi}) * di;
    pl <= $signed({1'b0, cfg.leak_rate}) * dl;
  end

  // Sum and round half up to the potential step
  assign s_sum = 36'(pe) + 36'(pi) + 36'(pl) + 36'sd32768;

  always_ff @(posedge clk) begin
    dv <= s_sum[35:16];
  end

  // New potential, saturate, threshold test
  always_comb begin
    nv = 21'(cur.potential) + 21'(dv);
    if (nv > 21'sd32767) begin
      v_sat = 16'sh7FFF;
    end else if (nv < -21'sd32768) begin
      v_sat = 16'sh8000;
    end else begin
      v_sat = nv[15:0];
    end
    spike   = active && (v_sat >= cfg.threshold);
    v_new   = !active ? cur.potential : (spike ? cfg.reset_level : v_sat);
    cnt_new = spike ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.out_index <= idx;
      out_data.spiked    <= in_range && spike;
      out_data.membrane  <= in_range ? v_new : '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/conductance_lif_neuron_update.sv -----
// Each input word passes in order through the steps read, decay, conductance
// update, drive products, sum and write back; a new word is taken only once
// the last one is written back, and a stalled result word holds the write back.
// Reset (rst, synchronous): registers return to their reset values, then a
// clearing pass writes every neuron's state; input stalls meanwhile, while
// configuration writes are taken at once.
`default_nettype none

module conductance_lif_neuron_update #(
  parameter int NEURONS          = 1024,
  parameter int REFRACTORY_TICKS = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input word channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire clif_pkg::clif_in_t                  in_data,
  // Result word channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output clif_pkg::clif_out_t                      out_data,
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [clif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [clif_pkg::VAL_W-1:0]          cfg_data
);

  clif_pkg::clif_cfg_t    cfg;
  clif_pkg::clif_cmd_t    cmd;
  clif_pkg::clif_status_t status;

  // Configuration registers take a word in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exc_decay    <= clif_pkg::RST_EXC_DECAY;
      cfg.inh_decay    <= clif_pkg::RST_INH_DECAY;
      cfg.leak_rate    <= clif_pkg::RST_LEAK_RATE;
      cfg.exc_reversal <= clif_pkg::RST_EXC_REVERSAL;
      cfg.inh_reversal <= clif_pkg::RST_INH_REVERSAL;
      cfg.rest_level   <= clif_pkg::RST_REST_LEVEL;
      cfg.threshold    <= clif_pkg::RST_THRESHOLD;
      cfg.reset_level  <= clif_pkg::RST_RESET_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clif_pkg::CFG_EXC_DECAY:    cfg.exc_decay    <= cfg_data;
        clif_pkg::CFG_INH_DECAY:    cfg.inh_decay    <= cfg_data;
        clif_pkg::CFG_LEAK_RATE:    cfg.leak_rate    <= cfg_data;
        clif_pkg::CFG_EXC_REVERSAL: cfg.exc_reversal <= cfg_data;
        clif_pkg::CFG_INH_REVERSAL: cfg.inh_reversal <= cfg_data;
        clif_pkg::CFG_REST_LEVEL:   cfg.rest_level   <= cfg_data;
        clif_pkg::CFG_THRESHOLD:    cfg.threshold    <= cfg_data;
        clif_pkg::CFG_RESET_LEVEL:  cfg.reset_level  <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Sequencer: clearing pass, then one item at a time through the steps.
  clif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and per-neuron state memory; holds the output register.
  clif_dp #(
    .NEURONS          (NEURONS),
    .REFRACTORY_TICKS (REFRACTORY_TICKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for conductance_lif_neuron_update: directed words, then
// random ticks across several register settings, checked against a local predictor.
// Depends on clif_pkg and the top-level RTL only.

module testbench;

  localparam int NEURON_COUNT   = 1024;
  localparam int REFRACTORY_LEN = 20;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 12;     // drain time after the queue empties
  localparam int HOLD_AT        = 350;    // result count that starts the long hold-off
  localparam int HOLD_CYCLES    = 300;
  localparam int TICKS_PER_SET  = 200;
  localparam int POOL_SIZE      = 6;
  localparam int REPORT_LIMIT   = 60;

  // Index past the end of the register list; the block must drop writes to it
  localparam logic [clif_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd12;

  typedef enum int {SET_HIGH_DRIVE, SET_LOW_DRIVE, SET_NEAR_REST, SET_SCRAMBLED} setting_e;

  localparam setting_e SCHEDULE [7] = '{
    SET_HIGH_DRIVE, SET_NEAR_REST, SET_LOW_DRIVE, SET_SCRAMBLED,
    SET_NEAR_REST, SET_SCRAMBLED, SET_NEAR_REST
  };

  // One row of the directed tour: the input word, and a result typed in by hand
  // where it can be read straight off the equations; other rows use the predictor.
  typedef struct packed {
    clif_pkg::clif_in_t  word;
    logic                typed;
    clif_pkg::clif_out_t result;
  } tour_row_t;

  localparam tour_row_t TOUR [17] = '{
    // fresh neuron at rest with no input: leak pulls nothing, potential holds
    '{'{10'd5,    16'd0,     16'd0},     1'b1, '{10'd5,    1'b0, -16'sd15360}},
    // full excitation drives the top neuron to the excitatory reversal and fires
    '{'{10'd1023, 16'hFFFF,  16'd0},     1'b1, '{10'd1023, 1'b1, -16'sd15360}},
    // right after the spike: refractory, potential held at reset level
    '{'{10'd1023, 16'd0,     16'd0},     1'b1, '{10'd1023, 1'b0, -16'sd15360}},
    // full inhibition pulls neuron 0 down onto the inhibitory reversal
    '{'{10'd0,    16'd0,     16'hFFFF},  1'b1, '{10'd0,    1'b0, -16'sd20480}},
    '{'{10'd0,    16'd0,     16'd0},     1'b0, '0},
    // stack full increments until both conductances saturate
    '{'{10'd7,    16'hFFFF,  16'hFFFF},  1'b0, '0},
    '{'{10'd7,    16'hFFFF,  16'hFFFF},  1'b0, '0},
    '{'{10'd7,    16'hFFFF,  16'hFFFF},  1'b0, '0},
    // half-scale conductance, then a decay step that lands exactly on a tie
    '{'{10'd100,  16'h8000,  16'h8000},  1'b0, '0},
    '{'{10'd100,  16'd0,     16'd0},     1'b0, '0},
    // alternating bit patterns on every field
    '{'{10'h2AA,  16'hAAAA,  16'h5555},  1'b0, '0},
    '{'{10'h155,  16'h5555,  16'hAAAA},  1'b0, '0},
    // still refractory: heavy drive must not fire
    '{'{10'd1023, 16'hFFFF,  16'd0},     1'b0, '0},
    // smallest nonzero increments
    '{'{10'd512,  16'd1,     16'd1},     1'b0, '0},
    '{'{10'd512,  16'd1,     16'd0},     1'b0, '0},
    // recover neuron 0 from deep inhibition
    '{'{10'd0,    16'h3000,  16'd0},     1'b0, '0},
    '{'{10'd0,    16'h3000,  16'd0},     1'b0, '0}
  };

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  clif_pkg::clif_in_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  clif_pkg::clif_out_t                 out_data;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [clif_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [clif_pkg::VAL_W-1:0]          cfg_data  = '0;

  // Predictor state: one copy of the per-neuron stores and the registers
  logic signed [clif_pkg::VAL_W-1:0] potential_mem [NEURON_COUNT];
  logic [clif_pkg::VAL_W-1:0]        g_exc_mem     [NEURON_COUNT];
  logic [clif_pkg::VAL_W-1:0]        g_inh_mem     [NEURON_COUNT];
  logic [clif_pkg::CNT_W-1:0]        since_mem     [NEURON_COUNT];
  clif_pkg::clif_cfg_t               live_cfg;

  clif_pkg::clif_out_t pending_results [$];   // predicted result words, oldest first
  int        fail_count   = 0;
  int        results_seen = 0;
  int        cycle_count  = 0;
  bit        calm         = 1'b0;   // no idling on either side once set

  conductance_lif_neuron_update #(
    .NEURONS          (NEURON_COUNT),
    .REFRACTORY_TICKS (REFRACTORY_LEN)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Decay a conductance with round-half-up loss, add the increment, clip at full scale.
  function automatic logic [clif_pkg::VAL_W-1:0] decay_conductance(
      input logic [clif_pkg::VAL_W-1:0] g,
      input logic [clif_pkg::VAL_W-1:0] rate,
      input logic [clif_pkg::VAL_W-1:0] inc);
    longint loss;
    longint sum;
    loss = (longint'(g) * longint'(rate) + 32768) >> 16;
    sum  = longint'(g) - loss + longint'(inc);
    return (sum > 65535) ? 16'hFFFF : 16'(sum);
  endfunction

  // Advance one neuron by a tick and return the result word it produces.
  function automatic clif_pkg::clif_out_t advance_neuron(input clif_pkg::clif_in_t w);
    int unsigned                n;
    logic [clif_pkg::VAL_W-1:0] ge;
    logic [clif_pkg::VAL_W-1:0] gi;
    logic [clif_pkg::CNT_W-1:0] cnt;
    longint                     v;
    longint                     drive;
    longint                     nv;
    clif_pkg::clif_out_t        r;
    n = w.neuron_index;
    r.out_index = w.neuron_index;
    r.spiked    = 1'b0;
    r.membrane  = '0;
    // Out-of-range index leaves every store alone (unreachable at 1024 neurons)
    if (n >= NEURON_COUNT) return r;

    ge = decay_conductance(g_exc_mem[n], live_cfg.exc_decay, w.exc_input);
    gi = decay_conductance(g_inh_mem[n], live_cfg.inh_decay, w.inh_input);
    g_exc_mem[n] = ge;
    g_inh_mem[n] = gi;

    v   = $signed(potential_mem[n]);
    cnt = since_mem[n];
    if (cnt != clif_pkg::CNT_MAX) cnt = cnt + 1'b1;

    // Integrate only once the refractory window has passed
    if (int'(cnt) > REFRACTORY_LEN) begin
      drive = longint'(ge) * (longint'($signed(live_cfg.exc_reversal)) - v)
            + longint'(gi) * (longint'($signed(live_cfg.inh_reversal)) - v)
            + longint'(live_cfg.leak_rate) * (longint'($signed(live_cfg.rest_level)) - v);
      nv = v + ((drive + 32768) >>> 16);
      if (nv > 32767)  nv = 32767;
      if (nv < -32768) nv = -32768;
      v = nv;
      if (v >= longint'($signed(live_cfg.threshold))) begin
        r.spiked = 1'b1;
        v   = $signed(live_cfg.reset_level);
        cnt = '0;
      end
    end

    potential_mem[n] = 16'(v);
    since_mem[n]     = cnt;
    r.membrane       = 16'(v);
    return r;
  endfunction

  // Offer one input word, hold it until taken, then queue its predicted result.
  // A fixed result, where given, replaces the prediction in the queue.
  task automatic send_word(input clif_pkg::clif_in_t w, input logic use_fixed,
                           input clif_pkg::clif_out_t fixed);
    clif_pkg::clif_out_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = advance_neuron(w);
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  // Write one register; valid stays up so back-to-back writes need no idle gap.
  task automatic write_register(input logic [clif_pkg::CFG_IDX_W-1:0] idx,
                                input logic [clif_pkg::VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      clif_pkg::CFG_EXC_DECAY:    live_cfg.exc_decay    = val;
      clif_pkg::CFG_INH_DECAY:    live_cfg.inh_decay    = val;
      clif_pkg::CFG_LEAK_RATE:    live_cfg.leak_rate    = val;
      clif_pkg::CFG_EXC_REVERSAL: live_cfg.exc_reversal = val;
      clif_pkg::CFG_INH_REVERSAL: live_cfg.inh_reversal = val;
      clif_pkg::CFG_REST_LEVEL:   live_cfg.rest_level   = val;
      clif_pkg::CFG_THRESHOLD:    live_cfg.threshold    = val;
      clif_pkg::CFG_RESET_LEVEL:  live_cfg.reset_level  = val;
      default: ;
    endcase
  endtask

  // Wait for every predicted word to come back, then let the pipeline empty.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mix of quiet, modest, strong and arbitrary conductance increments
  function automatic logic [clif_pkg::VAL_W-1:0] pick_increment();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'($urandom_range(0, 3000));
      2:       return 16'($urandom_range(0, 12000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: check each accepted word and stall in random bursts, plus one
  // long hold-off so the block backs up and stalls its input.
  always @(posedge clk) begin : result_sink
    clif_pkg::clif_out_t want;
    static int  stall_left = 0;
    static bit  hold_done  = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $error("result word for neuron %0d with nothing expected", out_data.out_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_index !== want.out_index) begin
          if (fail_count < REPORT_LIMIT)
            $error("out_index: expected %0d, actual %0d", want.out_index, out_data.out_index);
          fail_count++;
        end
        if (out_data.spiked !== want.spiked) begin
          if (fail_count < REPORT_LIMIT)
            $error("spiked: expected %0d, actual %0d (neuron %0d)",
                   want.spiked, out_data.spiked, want.out_index);
          fail_count++;
        end
        if (out_data.membrane !== want.membrane) begin
          if (fail_count < REPORT_LIMIT)
            $error("membrane: expected %0d, actual %0d (neuron %0d)",
                   want.membrane, out_data.membrane, want.out_index);
          fail_count++;
        end
      end
    end

    // Schedule the stall for the next cycle
    if (!hold_done && results_seen >= HOLD_AT) begin
      stall_left = HOLD_CYCLES;
      hold_done  = 1'b1;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    clif_pkg::clif_in_t         w;
    clif_pkg::clif_cfg_t        c;
    logic [clif_pkg::IDX_W-1:0] pool [POOL_SIZE];

    // Predictor starts from the reset image of the block
    live_cfg = '{
      exc_decay:    clif_pkg::RST_EXC_DECAY,
      inh_decay:    clif_pkg::RST_INH_DECAY,
      leak_rate:    clif_pkg::RST_LEAK_RATE,
      exc_reversal: clif_pkg::RST_EXC_REVERSAL,
      inh_reversal: clif_pkg::RST_INH_REVERSAL,
      rest_level:   clif_pkg::RST_REST_LEVEL,
      threshold:    clif_pkg::RST_THRESHOLD,
      reset_level:  clif_pkg::RST_RESET_LEVEL
    };
    for (int i = 0; i < NEURON_COUNT; i++) begin
      potential_mem[i] = clif_pkg::RST_REST_LEVEL;
      g_exc_mem[i]     = '0;
      g_inh_mem[i]     = '0;
      since_mem[i]     = clif_pkg::CNT_MAX;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed tour under the reset register values; input stalls through the
    // clearing pass, so the first word simply waits for it.
    foreach (TOUR[i]) send_word(TOUR[i].word, TOUR[i].typed, TOUR[i].result);
    in_valid <= 1'b0;

    foreach (SCHEDULE[p]) begin
      settle();
      calm = (p == $size(SCHEDULE) - 1);

      case (SCHEDULE[p])
        SET_HIGH_DRIVE: c = '{16'd0, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000,
                              16'sh7FFF, 16'sh7FFF, 16'sh8000};
        SET_LOW_DRIVE:  c = '{16'hFFFF, 16'd0, 16'd0, 16'sh8000, 16'sh7FFF,
                              16'sh8000, 16'sh8000, 16'sh7FFF};
        SET_NEAR_REST: begin
          c.exc_decay    = 16'($urandom_range(0, 4000));
          c.inh_decay    = 16'($urandom_range(0, 4000));
          c.leak_rate    = 16'($urandom_range(0, 2000));
          c.exc_reversal = 16'($urandom_range(0, 4000));
          c.inh_reversal = 16'(-int'($urandom_range(16000, 24000)));
          c.rest_level   = 16'(-int'($urandom_range(14000, 16000)));
          c.threshold    = 16'(-int'($urandom_range(11000, 13500)));
          c.reset_level  = 16'(-int'($urandom_range(14000, 17000)));
        end
        default: c = clif_pkg::clif_cfg_t'({$urandom, $urandom, $urandom, $urandom});
      endcase

      write_register(clif_pkg::CFG_EXC_DECAY,    c.exc_decay);
      write_register(clif_pkg::CFG_INH_DECAY,    c.inh_decay);
      write_register(clif_pkg::CFG_LEAK_RATE,    c.leak_rate);
      write_register(clif_pkg::CFG_EXC_REVERSAL, c.exc_reversal);
      write_register(clif_pkg::CFG_INH_REVERSAL, c.inh_reversal);
      write_register(clif_pkg::CFG_REST_LEVEL,   c.rest_level);
      write_register(clif_pkg::CFG_THRESHOLD,    c.threshold);
      write_register(clif_pkg::CFG_RESET_LEVEL,  c.reset_level);
      // Last, so an index that aliases onto a real register would show up
      write_register(CFG_SPARE,                  16'($urandom));
      cfg_valid <= 1'b0;

      // A handful of neurons take most ticks so conductances build up and the
      // refractory window opens and closes; the rest land anywhere.
      pool[0] = '0;
      pool[POOL_SIZE-1] = '1;
      for (int k = 1; k < POOL_SIZE - 1; k++) pool[k] = clif_pkg::IDX_W'($urandom);

      for (int k = 0; k < TICKS_PER_SET; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          w.neuron_index = pool[$urandom_range(0, POOL_SIZE - 1)];
          w.exc_input    = pick_increment();
          w.inh_input    = pick_increment();
        end else begin
          w = clif_pkg::clif_in_t'({$urandom, $urandom});
        end
        send_word(w, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
